FILE: src/laqs_pkg.sv
// shared types and constants of the linear array queue with search
// no dependencies; imported by every module of the block
package laqs_pkg;

    // queue geometry
    localparam int unsigned DEPTH    = 64;
    localparam int unsigned IDX_W    = $clog2(DEPTH);
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned POS_W    = 7;
    localparam int unsigned DATA_W   = 32;

    // command queue between front and back
    localparam int unsigned CQ_DEPTH = 2;
    localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // command codes
    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_SEARCH   = 3'd2,
        CMD_COUNT    = 3'd3,
        CMD_SHOW_FWD = 3'd4,
        CMD_SHOW_REV = 3'd5
    } t_cmd_e;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status_e;

    // input word as it arrives
    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    // result word
    typedef struct packed {
        t_status_e                status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_out_word;

    // classified command held in the command queue
    typedef struct packed {
        t_cmd_e                   cmd;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // queue indexes seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] head;
        logic [CNT_W-1:0] tail;
    } t_q_stat;

endpackage

FILE: src/laqs_front.sv
// front end: accepts input words, drops unused codes, queues valid commands
// depends on laqs_pkg
module laqs_front import laqs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_word i_item,
    output logic     o_cmd_vld,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);

    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic                accept;
    logic                known;
    logic                wr;
    logic                rd;

    // classify the incoming word
    assign full   = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign accept = push && !full;
    assign known  = (i_item.cmd <= 3'(CMD_SHOW_REV));
    assign wr     = accept && known;
    assign rd     = i_cmd_take && (r_cnt != '0);

    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{cmd: t_cmd_e'(i_item.cmd), value: i_item.value};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/laqs_back.sv
// back end: entry memory, head and tail, command sequencer and result register
// depends on laqs_pkg
module laqs_back import laqs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_vld,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_result,
    output t_q_stat   o_stat
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state_e;

    logic [DATA_W-1:0]        r_mem [DEPTH];
    logic [DATA_W-1:0]        r_rd;

    t_state_e                 r_state, n_state;
    t_cmd_e                   r_op, n_op;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]         r_cur, n_cur;
    logic [CNT_W-1:0]         r_head, n_head;
    logic [CNT_W-1:0]         r_tail, n_tail;
    t_out_word                r_out, n_out;
    logic                     r_out_vld, n_out_vld;

    logic                     out_free;
    logic                     q_empty;
    logic                     at_end;
    logic                     at_beg;
    logic                     match;
    logic                     we;
    logic [IDX_W-1:0]         rd_addr;
    logic [CNT_W-1:0]         cur_inc;
    logic [CNT_W-1:0]         cur_dec;
    logic [CNT_W-1:0]         tail_dec;

    assign out_free = !r_out_vld || pop;
    assign q_empty  = (r_head == r_tail);
    assign cur_inc  = r_cur + 1'b1;
    assign cur_dec  = r_cur - 1'b1;
    assign tail_dec = r_tail - 1'b1;
    assign at_end   = (cur_inc == r_tail);
    assign at_beg   = (r_cur == r_head);
    assign match    = (r_rd == r_val);

    assign empty    = !r_out_vld;
    assign o_result = r_out;
    assign o_stat   = '{head: r_head, tail: r_tail};

    // sequencer next state and result selection
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_val      = r_val;
        n_cur      = r_cur;
        n_head     = r_head;
        n_tail     = r_tail;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !pop;
        o_cmd_take = 1'b0;
        we         = 1'b0;
        rd_addr    = r_cur[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_vld && out_free) begin
                    o_cmd_take = 1'b1;
                    n_op       = i_cmd.cmd;
                    n_val      = i_cmd.value;
                    n_out      = '{status: ST_OK, data: '0, position: '0, last: 1'b1};
                    unique case (i_cmd.cmd) inside
                        CMD_INSERT: begin
                            n_out_vld = 1'b1;
                            if (r_tail == CNT_W'(DEPTH)) begin
                                n_out.status = ST_OVERFLOW;
                            end else begin
                                we     = 1'b1;
                                n_tail = r_tail + 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH, CMD_SHOW_FWD: begin
                            if (q_empty) begin
                                n_out_vld    = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                rd_addr = r_head[IDX_W-1:0];
                                n_cur   = r_head;
                                n_state = S_WALK;
                            end
                        end
                        CMD_SHOW_REV: begin
                            if (q_empty) begin
                                n_out_vld    = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                rd_addr = tail_dec[IDX_W-1:0];
                                n_cur   = tail_dec;
                                n_state = S_WALK;
                            end
                        end
                        CMD_COUNT: begin
                            n_out_vld      = 1'b1;
                            n_out.position = POS_W'(r_tail - r_head);
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // r_rd holds the entry at slot r_cur
                if (out_free) begin
                    n_out = '{status: ST_OK, data: r_rd, position: '0, last: 1'b1};
                end
                case (r_op)
                    CMD_REMOVE: begin
                        if (out_free) begin
                            n_out_vld = 1'b1;
                            n_head    = r_head + 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    CMD_SEARCH: begin
                        if (match || at_end) begin
                            if (out_free) begin
                                n_out_vld      = 1'b1;
                                n_out.data     = '0;
                                n_out.status   = match ? ST_OK : ST_NOT_FOUND;
                                n_out.position = match ? POS_W'(r_cur) : '0;
                                n_state        = S_IDLE;
                            end
                        end else begin
                            n_cur   = cur_inc;
                            rd_addr = cur_inc[IDX_W-1:0];
                        end
                    end
                    CMD_SHOW_FWD: begin
                        if (out_free) begin
                            n_out_vld  = 1'b1;
                            n_out.last = at_end;
                            if (at_end) begin
                                n_state = S_IDLE;
                            end else begin
                                n_cur   = cur_inc;
                                rd_addr = cur_inc[IDX_W-1:0];
                            end
                        end
                    end
                    CMD_SHOW_REV: begin
                        if (out_free) begin
                            n_out_vld  = 1'b1;
                            n_out.last = at_beg;
                            if (at_beg) begin
                                n_state = S_IDLE;
                            end else begin
                                n_cur   = cur_dec;
                                rd_addr = cur_dec[IDX_W-1:0];
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_tail[IDX_W-1:0]] <= i_cmd.value;
        end
        r_rd <= r_mem[rd_addr];
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_out_vld <= n_out_vld;
        end
        r_op  <= n_op;
        r_val <= n_val;
        r_cur <= n_cur;
        r_out <= n_out;
    end

endmodule

FILE: src/linear_array_queue_with_search.sv
// top level of the linear array queue with search
// depends on laqs_pkg, laqs_front and laqs_back
//
//   channel   handshake          word
//   input     push / full        i_item   (cmd, value)
//   result    pop / empty        o_result (status, data, position, last)
//
// insert, count and any command on an empty queue give their result in the back end with no memory read
// remove does one memory read, then gives the result
// search and show walk the n live entries: one memory read per slot
// a full result register stalls the walk at its next result; the two-word command queue keeps taking input until full
// reset clears head, tail and all valid state; no memory clearing pass
module linear_array_queue_with_search import laqs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_result
);

    logic    cmd_vld;
    t_cmd    cmd;
    logic    cmd_take;
    t_q_stat stat;

    // accept and classify
    laqs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_take (cmd_take)
    );

    // carry out commands
    laqs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_take (cmd_take),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .o_stat     (stat)
    );

    // head never passes tail
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.head <= stat.tail)
        else $error("head index passed tail index");

    // tail never passes the depth
    a_tail_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.tail <= CNT_W'(DEPTH))
        else $error("tail index beyond depth");

    // tail only holds or steps up by one
    a_tail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (stat.tail != $past(stat.tail))
            |-> (stat.tail == $past(stat.tail) + 1'b1))
        else $error("tail index moved by other than one");

    // head only holds or steps up by one
    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (stat.head != $past(stat.head))
            |-> (stat.head == $past(stat.head) + 1'b1))
        else $error("head index moved by other than one");

endmodule
